[hw/rtl/a85le_pkg.sv]
// Shared types and constants for the ASCII85 line encoder.
package a85le_pkg;

	localparam logic [7:0] GPL_RESET = 8'd24;
	localparam int QUEUE_DEPTH_DEF = 4;

	// Character slots that one queued command may expand into, in output order.
	localparam int NSLOT = 10;
	localparam logic [3:0] SLOT_SPACE = 4'd0;
	localparam logic [3:0] SLOT_D0 = 4'd1;
	localparam logic [3:0] SLOT_D1 = 4'd2;
	localparam logic [3:0] SLOT_D2 = 4'd3;
	localparam logic [3:0] SLOT_D3 = 4'd4;
	localparam logic [3:0] SLOT_D4 = 4'd5;
	localparam logic [3:0] SLOT_NL = 4'd6;
	localparam logic [3:0] SLOT_TILDE = 4'd7;
	localparam logic [3:0] SLOT_GT = 4'd8;
	localparam logic [3:0] SLOT_END = 4'd9;

	// floor(v / 85) == (v * RECIP_85) >> RECIP_SHIFT for every 32-bit v
	localparam logic [31:0] RECIP_85 = 32'hC0C0_C0C1;
	localparam int RECIP_SHIFT = 38;

	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_Z = 8'h7A;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_GT = 8'h3E;

	// digit values of '%' and '!'
	localparam logic [6:0] DIG_PCT = 7'd4;
	localparam logic [6:0] DIG_BANG = 7'd0;

	typedef logic [6:0] digit_t;

	typedef struct packed {
		logic [NSLOT-1:0] mask;     // slots to emit
		logic             is_z;     // first digit slot carries 'z'
		digit_t [4:0]     digits;   // digits[0] most significant
	} cmd_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_PUSH
	} front_state_t;

endpackage

[hw/rtl/a85le_front.sv]
// Front end: byte packing, group/line/close classification and base-85 conversion.
module a85le_front
	import a85le_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       in_close,
	output logic       push,
	output cmd_t       push_cmd,
	input  logic       full
);

	front_state_t state_q, state_nxt;

	logic [7:0]  gpl_q;
	logic [31:0] grp_q;
	logic [1:0]  nb_q;
	logic [7:0]  gil_q;
	logic        lho_q;

	// pending command
	logic [31:0] conv_q;
	digit_t [3:0] lo_q;
	logic [1:0]  it_q;
	logic        has_grp_q;
	logic        zero_q;
	logic [2:0]  nd_q;
	logic        lho_before_q;
	logic        nl_q;
	logic        term_q;

	logic        accept;
	logic        take;
	logic        closing;
	logic [31:0] grp_new;
	logic [2:0]  nb_new;
	logic        full_grp;
	logic        partial;
	logic        has_grp;
	logic        zero;
	logic [8:0]  gil_inc;
	logic [8:0]  limit;
	logic        line_end;
	logic        lho_mid;
	logic        nl;
	logic [31:0] gvalue;
	logic [2:0]  nd;
	logic        need_push;

	logic [63:0] prod;
	logic [31:0] quo;
	logic [31:0] quo85;
	logic [31:0] rem;

	assign accept = in_valid && in_ready;
	assign take = !in_close;
	assign closing = in_close || in_last;
	assign grp_new = take ? {grp_q[23:0], in_byte} : grp_q;
	assign nb_new = {1'b0, nb_q} + {2'b00, take};
	assign full_grp = take && (nb_q == 2'd3);
	assign partial = closing && !full_grp && (nb_new != 3'd0);
	assign has_grp = full_grp || partial;
	assign gil_inc = {1'b0, gil_q} + 9'd1;
	assign limit = (gpl_q == 8'd0) ? 9'd1 : {1'b0, gpl_q};
	assign line_end = full_grp && (gil_inc >= limit);
	assign lho_mid = has_grp ? !line_end : lho_q;
	assign nl = line_end || (closing && lho_mid);
	assign zero = full_grp && (grp_new == 32'd0);
	assign need_push = has_grp || closing;

	always_comb begin
		gvalue = grp_new;
		nd = 3'd5;
		if (!full_grp) begin
			nd = nb_new + 3'd1;
			case (nb_new[1:0])
				2'd1: gvalue = {grp_new[7:0], 24'd0};
				2'd2: gvalue = {grp_new[15:0], 16'd0};
				2'd3: gvalue = {grp_new[23:0], 8'd0};
				default: gvalue = grp_new;
			endcase
		end
	end

	// one base-85 digit per cycle, least significant first
	assign prod = {32'd0, conv_q} * {32'd0, RECIP_85};
	assign quo = 32'(prod >> RECIP_SHIFT);
	assign quo85 = (quo << 6) + (quo << 4) + (quo << 2) + quo;
	assign rem = conv_q - quo85;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept && need_push)
					state_nxt = (has_grp && !zero) ? F_CONV : F_PUSH;
			end
			F_CONV: begin
				if (it_q == 2'd3)
					state_nxt = F_PUSH;
			end
			F_PUSH: begin
				if (!full)
					state_nxt = F_IDLE;
			end
			default: state_nxt = F_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		push = 1'b0;
		case (state_q)
			F_IDLE: in_ready = 1'b1;
			F_PUSH: push = !full;
			default: begin
				in_ready = 1'b0;
				push = 1'b0;
			end
		endcase
	end

	// command assembly
	always_comb begin
		logic [6:0] d0;
		d0 = conv_q[6:0];
		push_cmd = '0;
		push_cmd.is_z = zero_q;
		push_cmd.digits = {lo_q[3], lo_q[2], lo_q[1], lo_q[0], d0};
		push_cmd.mask[SLOT_SPACE] = has_grp_q && !zero_q && !lho_before_q &&
			(d0 == DIG_PCT) && ((lo_q[0] == DIG_PCT) || (lo_q[0] == DIG_BANG));
		push_cmd.mask[SLOT_D0] = has_grp_q;
		push_cmd.mask[SLOT_D1] = has_grp_q && !zero_q && (nd_q >= 3'd2);
		push_cmd.mask[SLOT_D2] = has_grp_q && !zero_q && (nd_q >= 3'd3);
		push_cmd.mask[SLOT_D3] = has_grp_q && !zero_q && (nd_q >= 3'd4);
		push_cmd.mask[SLOT_D4] = has_grp_q && !zero_q && (nd_q >= 3'd5);
		push_cmd.mask[SLOT_NL] = nl_q;
		push_cmd.mask[SLOT_TILDE] = term_q;
		push_cmd.mask[SLOT_GT] = term_q;
		push_cmd.mask[SLOT_END] = term_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			gpl_q <= GPL_RESET;
			grp_q <= '0;
			nb_q <= '0;
			gil_q <= '0;
			lho_q <= 1'b0;
			it_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr_en)
				gpl_q <= cfg_wr_data;
			if (accept) begin
				grp_q <= (full_grp || closing) ? 32'd0 : grp_new;
				nb_q <= (full_grp || closing) ? 2'd0 : nb_new[1:0];
				if (closing || line_end)
					gil_q <= '0;
				else if (full_grp)
					gil_q <= gil_inc[7:0];
				lho_q <= closing ? 1'b0 : lho_mid;
				it_q <= '0;
			end else if (state_q == F_CONV) begin
				it_q <= it_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			conv_q <= gvalue;
			has_grp_q <= has_grp;
			zero_q <= zero;
			nd_q <= nd;
			lho_before_q <= lho_q;
			nl_q <= nl;
			term_q <= closing;
		end else if (state_q == F_CONV) begin
			conv_q <= quo;
			lo_q <= {lo_q[2:0], rem[6:0]};
		end
	end

endmodule

[hw/rtl/a85le_queue.sv]
// Small register queue of character commands between front and back.
module a85le_queue
	import a85le_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	cmd_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

endmodule

[hw/rtl/a85le_back.sv]
// Back end: queued commands become output-register characters, one per cycle unless stalled.
module a85le_back
	import a85le_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        head,
	input  logic        empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_char,
	output logic        out_last,
	output logic [31:0] out_total
);

	logic [NSLOT-1:0] done_q;
	logic [31:0]      cnt_q;
	logic             valid_q;
	logic [7:0]       char_q;
	logic             last_q;
	logic [31:0]      total_q;

	logic [NSLOT-1:0] rem;
	logic [3:0]       slot;
	logic             only_one;
	logic             load;
	logic [7:0]       ch;
	logic             is_end;

	assign rem = head.mask & ~done_q;
	assign only_one = ((rem & (rem - NSLOT'(1))) == '0);
	assign load = !empty && (!valid_q || out_ready);
	assign pop = load && only_one;
	assign is_end = (slot == SLOT_END);

	// lowest pending slot
	always_comb begin
		slot = SLOT_END;
		for (int i = NSLOT - 1; i >= 0; i--) begin
			if (rem[i])
				slot = 4'(i);
		end
	end

	always_comb begin
		case (slot)
			SLOT_SPACE: ch = CH_SP;
			SLOT_D0:    ch = head.is_z ? CH_Z : {1'b0, head.digits[0]} + CH_BANG;
			SLOT_D1:    ch = {1'b0, head.digits[1]} + CH_BANG;
			SLOT_D2:    ch = {1'b0, head.digits[2]} + CH_BANG;
			SLOT_D3:    ch = {1'b0, head.digits[3]} + CH_BANG;
			SLOT_D4:    ch = {1'b0, head.digits[4]} + CH_BANG;
			SLOT_NL:    ch = CH_NL;
			SLOT_TILDE: ch = CH_TILDE;
			SLOT_GT:    ch = CH_GT;
			SLOT_END:   ch = CH_NL;
			default:    ch = CH_NL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
			cnt_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				done_q <= pop ? '0 : (done_q | (NSLOT'(1) << slot));
				cnt_q <= is_end ? 32'd0 : cnt_q + 32'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= ch;
			last_q <= is_end;
			total_q <= is_end ? cnt_q + 32'd1 : 32'd0;
		end
	end

	assign out_valid = valid_q;
	assign out_char = char_q;
	assign out_last = last_q;
	assign out_total = total_q;

endmodule

[hw/rtl/ascii85_line_encoder_top.sv]
// ASCII85 line encoder: top level joining front end, command queue and back end.
// Bytes enter on the slave stream (tuser[0] closes the stream without a byte, tlast marks the
// final byte) and ASCII85 characters leave on the master stream, one per transaction; tlast marks
// the final "\n" of "~>\n", which also carries the character total in tdata[39:8]. A byte that
// neither completes a group nor closes the stream leaves the input ready. A byte that completes a
// nonzero group, or closes a partial one, holds the input while the base-85 unit (one reciprocal multiply
// per lower digit) produces the digits and then until the command is queued; a byte that completes
// an all-zero group, and a close with no bytes pending, hold it only until their command is queued.
// The back end emits one character per cycle while the receiver is ready, so the queue absorbs the
// bursts at group and line ends; a full queue stalls the input. groups_per_line must be written
// through cfg_wr_en/cfg_wr_data by the user only while the block is idle; the block does not enforce this.
module ascii85_line_encoder_top
	import a85le_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,    // groups_per_line
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // last_byte
	input  logic [0:0]  s_axis_tuser,   // [0] close_only
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [7:0] out_char, [39:8] total_chars
	output logic        m_axis_tlast    // last_char
);

	logic        push;
	cmd_t        push_cmd;
	logic        full;
	logic        pop;
	cmd_t        head;
	logic        empty;
	logic [7:0]  out_char;
	logic [31:0] total_chars;

	a85le_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_byte     (s_axis_tdata),
		.in_last     (s_axis_tlast),
		.in_close    (s_axis_tuser[0]),
		.push        (push),
		.push_cmd    (push_cmd),
		.full        (full)
	);

	a85le_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	a85le_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (out_char),
		.out_last  (m_axis_tlast),
		.out_total (total_chars)
	);

	assign m_axis_tdata = {total_chars, out_char};

`ifndef SYNTHESIS
	// the stream always ends on the newline after "~>"
	a_last_is_nl: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[7:0] == CH_NL))
		else $error("final character is not a newline");

	// total is only reported with the final character
	a_total_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[39:8] == 32'd0))
		else $error("character total on a non-final character");

	// queue never pushed while full, never popped while empty
	a_queue_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && empty))
		else $error("command queue overflow or underflow");

	// output transaction held while the receiver stalls
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
		else $error("output changed while stalled");
`endif

endmodule

[tb/sv/tb_ascii85_line_encoder_top.sv]
// Self-checking testbench for the ASCII85 line encoder top level.
`timescale 1ns / 100ps

module tb_ascii85_line_encoder_top
	import a85le_pkg::*;
();

	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_CYCLES = 160;
	localparam int PHASE_ITEMS = 45;
	// words whose leading digits are '%' '!' and '%' '%'
	localparam logic [31:0] PCT_BANG_BASE = 32'd208802500;
	localparam logic [31:0] PCT_PCT_BASE = 32'd211259000;

	typedef struct packed {
		logic [7:0]  ch;
		logic        fin;
		logic [31:0] total;
	} char_rec_t;

	typedef struct {
		logic [7:0]  d;
		bit          lst;
		bit          cls;
		bit          typed;
		string       want;
		int unsigned want_total;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [7:0]  cfg_wr_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] data_byte
	logic        s_axis_tlast;
	logic [0:0]  s_axis_tuser;   // [0] close_only
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // [7:0] out_char, [39:8] total_chars
	logic        m_axis_tlast;

	// encoder shadow state
	logic [7:0]  line_limit;
	logic [31:0] grp_word;
	int          grp_bytes;
	int          line_groups;
	bit          line_busy;
	logic [31:0] emitted;
	char_rec_t   staged[$];
	char_rec_t   char_q[$];

	int tx_idle_pct;
	int rx_stall_pct;
	int hold_req;
	int items_done;
	int mismatches;
	int stall_cycles;

	stim_row_t dir_tab[25] = '{
		'{8'h00, 1'b0, 1'b1, 1'b1, "~>\n", 3},
		'{8'hFF, 1'b1, 1'b1, 1'b1, "~>\n", 3},
		'{8'h00, 1'b0, 1'b0, 1'b1, "", 0},
		'{8'h00, 1'b0, 1'b0, 1'b1, "", 0},
		'{8'h00, 1'b0, 1'b0, 1'b1, "", 0},
		'{8'h00, 1'b0, 1'b0, 1'b1, "z", 0},
		'{8'h00, 1'b1, 1'b0, 1'b1, "!!\n~>\n", 7},
		'{8'hFF, 1'b0, 1'b0, 1'b1, "", 0},
		'{8'hFF, 1'b0, 1'b0, 1'b1, "", 0},
		'{8'hFF, 1'b0, 1'b0, 1'b1, "", 0},
		'{8'hFF, 1'b1, 1'b0, 1'b1, "s8W-!\n~>\n", 9},
		'{8'h0C, 1'b0, 1'b0, 1'b0, "", 0},
		'{8'h72, 1'b0, 1'b0, 1'b0, "", 0},
		'{8'h12, 1'b0, 1'b0, 1'b0, "", 0},
		'{8'hC4, 1'b0, 1'b0, 1'b0, "", 0},
		'{8'h0C, 1'b0, 1'b0, 1'b0, "", 0},
		'{8'h97, 1'b0, 1'b0, 1'b0, "", 0},
		'{8'h8E, 1'b0, 1'b0, 1'b0, "", 0},
		'{8'h78, 1'b0, 1'b0, 1'b0, "", 0},
		'{8'hFF, 1'b0, 1'b0, 1'b0, "", 0},
		'{8'hFF, 1'b0, 1'b0, 1'b0, "", 0},
		'{8'hFF, 1'b1, 1'b0, 1'b0, "", 0},
		'{8'hAB, 1'b0, 1'b0, 1'b0, "", 0},
		'{8'hCD, 1'b0, 1'b0, 1'b0, "", 0},
		'{8'h55, 1'b0, 1'b1, 1'b0, "", 0}
	};

	ascii85_line_encoder_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void emit(input logic [7:0] c);
		char_rec_t rec;
		rec.ch = c;
		rec.fin = 1'b0;
		rec.total = '0;
		staged.push_back(rec);
		emitted = emitted + 1;
		line_busy = (c != CH_NL);
	endfunction

	// base-85 digits of v, leading space when a line would open with %% or %!
	function automatic void emit_digits(input logic [31:0] v, input int ndig);
		logic [6:0]  dig [5];
		logic [31:0] rest;
		int          j;
		rest = v;
		for (j = 4; j >= 0; j--) begin
			dig[j] = 7'(rest % 85);
			rest = rest / 85;
		end
		if (!line_busy && dig[0] == DIG_PCT && (dig[1] == DIG_PCT || dig[1] == DIG_BANG))
			emit(CH_SP);
		for (j = 0; j < ndig; j++)
			emit(CH_BANG + {1'b0, dig[j]});
	endfunction

	function automatic void encode_item(input logic [7:0] d, input bit lst, input bit cls);
		int lim;
		staged.delete();
		if (!cls) begin
			grp_word = {grp_word[23:0], d};
			grp_bytes++;
			if (grp_bytes == 4) begin
				lim = (line_limit == 0) ? 1 : int'(line_limit);
				if (grp_word == 0)
					emit(CH_Z);
				else
					emit_digits(grp_word, 5);
				grp_word = '0;
				grp_bytes = 0;
				line_groups++;
				if (line_groups >= lim) begin
					emit(CH_NL);
					line_groups = 0;
				end
			end
		end
		if (cls || lst) begin
			if (grp_bytes != 0)
				emit_digits(grp_word << (8 * (4 - grp_bytes)), grp_bytes + 1);
			if (line_busy)
				emit(CH_NL);
			emit(CH_TILDE);
			emit(CH_GT);
			emit(CH_NL);
			staged[staged.size() - 1].fin = 1'b1;
			staged[staged.size() - 1].total = emitted;
			grp_word = '0;
			grp_bytes = 0;
			line_groups = 0;
			line_busy = 0;
			emitted = '0;
		end
	endfunction

	function automatic logic [31:0] pick_word();
		int   style;
		logic [31:0] w;
		style = $urandom_range(0, 7);
		case (style)
			0, 1: w = '0;
			2: w = PCT_BANG_BASE + $urandom_range(0, 614124);
			3: w = PCT_PCT_BASE + $urandom_range(0, 614124);
			4: w = {{8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}},
				{8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}}};
			default: w = $urandom;
		endcase
		return w;
	endfunction

	// one input transaction; typed rows replace the shadow's prediction
	task automatic send_item(input logic [7:0] d, input bit lst, input bit cls, input bit typed,
			input string want, input int unsigned want_total);
		char_rec_t rec;
		int        k;
		@(negedge clk);
		while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tlast <= lst;
		s_axis_tuser <= cls;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		encode_item(d, lst, cls);
		if (typed) begin
			for (k = 0; k < want.len(); k++) begin
				rec.ch = want[k];
				rec.fin = (k == want.len() - 1) && (lst || cls);
				rec.total = rec.fin ? want_total : 32'd0;
				char_q.push_back(rec);
			end
		end else begin
			for (k = 0; k < staged.size(); k++)
				char_q.push_back(staged[k]);
		end
		items_done++;
	endtask

	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (char_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_gpl(input logic [7:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		line_limit = v;
	endtask

	task automatic random_stream(input int min_len);
		int          len;
		int          i;
		int          pick;
		bit          via_close;
		logic [31:0] w;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			len = 0;
		else if (pick <= 6)
			len = $urandom_range(1, 24);
		else if (pick <= 8)
			len = $urandom_range(25, 60);
		else
			len = $urandom_range(61, 120);
		if (len < min_len)
			len = min_len;
		via_close = (len == 0) || ($urandom_range(0, 2) == 0);
		w = '0;
		for (i = 0; i < len; i++) begin
			if (i % 4 == 0)
				w = pick_word();
			send_item(w[31 - 8 * (i % 4) -: 8], !via_close && i == len - 1, 1'b0, 1'b0, "", 0);
		end
		if (via_close)
			send_item(8'($urandom_range(0, 255)), $urandom_range(0, 1) == 1, 1'b1, 1'b0, "", 0);
	endtask

	task automatic run_phase(input logic [7:0] gpl, input int tx_pct, input int rx_pct,
			input bit hold);
		int target;
		settle();
		write_gpl(gpl);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		target = items_done + PHASE_ITEMS;
		if (hold) begin
			hold_req = HOLD_CYCLES;
			random_stream(40);
		end
		while (items_done < target) begin
			random_stream(0);
			if ($urandom_range(0, 9) == 0)
				settle();
		end
	endtask

	// receiver: random stalls plus an occasional long hold-off
	initial begin : rx_side
		int hold_left;
		hold_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	initial begin : out_check
		char_rec_t rec;
		stall_cycles = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (char_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected character %h (last %b total %0d)",
							m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[39:8]);
				end else begin
					rec = char_q.pop_front();
					if (m_axis_tdata[7:0] !== rec.ch || m_axis_tlast !== rec.fin ||
							m_axis_tdata[39:8] !== rec.total) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: char exp %h got %h, last exp %b got %b, total exp %0d got %0d",
								rec.ch, m_axis_tdata[7:0], rec.fin, m_axis_tlast,
								rec.total, m_axis_tdata[39:8]);
					end
				end
			end
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	initial begin : watchdog
		@(posedge arst_n);
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("FAIL ascii85_line_encoder_top");
		$finish;
	end

	initial begin : main_seq
		int i;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		s_axis_tuser = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_req = 0;
		items_done = 0;
		mismatches = 0;
		line_limit = GPL_RESET;
		grp_word = '0;
		grp_bytes = 0;
		line_groups = 0;
		line_busy = 0;
		emitted = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < $size(dir_tab); i++)
			send_item(dir_tab[i].d, dir_tab[i].lst, dir_tab[i].cls, dir_tab[i].typed,
				dir_tab[i].want, dir_tab[i].want_total);

		// shorten the line while three groups already sit on it
		settle();
		write_gpl(8'd6);
		for (i = 0; i < 12; i++)
			send_item(8'($urandom_range(1, 255)), 1'b0, 1'b0, 1'b0, "", 0);
		settle();
		write_gpl(8'd2);
		for (i = 0; i < 8; i++)
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, "", 0);
		send_item(8'h00, 1'b0, 1'b1, 1'b0, "", 0);

		run_phase(8'd1, 0, 0, 1'b0);
		run_phase(8'd255, 47, 0, 1'b0);
		run_phase(8'd0, 0, 47, 1'b0);
		run_phase(8'($urandom_range(2, 8)), 16, 16, 1'b0);
		run_phase(8'd3, 0, 0, 1'b1);
		run_phase(8'($urandom_range(1, 255)), 47, 0, 1'b0);

		settle();
		if (char_q.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("PASS ascii85_line_encoder_top");
		else
			$display("FAIL ascii85_line_encoder_top");
		$finish;
	end

endmodule
